>>> sv/lcmc_pkg.sv
// ----------------------------------------------------------------------------
// lcmc_pkg
// Shared types and constants of the lattice chain move unit: lattice and
// chain sizes, request and result formats, step vectors and exp factors.
// ----------------------------------------------------------------------------
package lcmc_pkg;

  localparam int NUM_CHAINS      = 36;
  localparam int BEADS_PER_CHAIN = 20;
  localparam int BOX_X           = 7;
  localparam int BOX_Y           = 7;
  localparam int BOX_Z           = 20;

  localparam int NBEADS = NUM_CHAINS * BEADS_PER_CHAIN;
  localparam int NSITES = BOX_X * BOX_Y * BOX_Z;
  localparam int BIDX_W = $clog2(NBEADS);
  localparam int SIDX_W = $clog2(NSITES);

  localparam int X_W       = 3;
  localparam int Y_W       = 3;
  localparam int Z_W       = 5;
  localparam int CNT_W     = 5;
  localparam int CNT_MAX   = 31;
  localparam int E_W       = 24;
  localparam int RND_W     = 16;
  localparam int CHAIN_W   = 6;
  localparam int BEAD_W    = 5;
  localparam int DIR_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int EXP_N_MAX = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTRACT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP = 2'd1;

  localparam logic signed [E_W-1:0] ATTRACT_RST = 24'sd0;
  localparam logic signed [E_W-1:0] OVERLAP_RST = 24'sd51200;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_FIRST = 2'd1,
    CMD_LAST  = 2'd2,
    CMD_INNER = 2'd3
  } cmd_e;

  localparam logic [DIR_W-1:0] DIR_LAST = 3'd5;

  localparam logic signed [1:0] STEP_X [6] = '{2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0};
  localparam logic signed [1:0] STEP_Y [6] = '{2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0};
  localparam logic signed [1:0] STEP_Z [6] = '{2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1};

  localparam logic [24:0] ONE_Q24 = 25'd16777216;
  localparam logic [23:0] EXP_ONE = 24'd6171993;
  localparam logic [23:0] EXP_FRAC [8] = '{
    24'd10175896, 24'd13066109, 24'd14805841, 24'd15760736,
    24'd16261035, 24'd16517109, 24'd16646655, 24'd16711808
  };

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [Z_W-1:0] z;
  } coord_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [CHAIN_W-1:0] chain_id;
    logic [BEAD_W-1:0]  bead_id;
    logic [DIR_W-1:0]   direction;
    logic [X_W-1:0]     load_x;
    logic [Y_W-1:0]     load_y;
    logic [Z_W-1:0]     load_z;
    logic [RND_W-1:0]   rand_frac;
  } req_t;

  typedef struct packed {
    logic                  accepted;
    logic [X_W-1:0]        new_x;
    logic [Y_W-1:0]        new_y;
    logic [Z_W-1:0]        new_z;
    logic signed [E_W-1:0] energy_change;
    logic                  bad_request;
  } res_t;

endpackage

>>> sv/lattice_chain_monte_carlo_move_unit.sv
// ----------------------------------------------------------------------------
// lattice_chain_monte_carlo_move_unit
// Bead coordinate and site occupancy stores with a sequenced Metropolis move.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low; busy stays
// high until the result has been issued. The result appears on res_o for one
// cycle, marked by result_valid_o, and is taken at the edge ending that cycle.
// The receiver cannot stall the block.
// Configuration writes (attract and overlap energy) go over cfg_valid_i /
// cfg_ready_o and are always taken; write them only while the block is idle.
// A refused request goes straight to the result; a load writes the bead,
// then increments its site count. A move does the bead reads, the target
// count read, the neighbour count reads when the target is empty, the
// product and saturation, the exp multiplier (one factor a cycle), and the
// count read-modify-write of both sites when accepted. Both stores are
// single port, so the count scan and the exp iteration set the rate.
// After reset the count store is cleared, one site a cycle, with busy high;
// the bead store is not cleared and must be loaded before moves.
// ----------------------------------------------------------------------------
module lattice_chain_monte_carlo_move_unit import lcmc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  result_valid_o,
  output res_t                  res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic signed [E_W-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_LD0, ST_LD1, ST_RD, ST_PROP, ST_CNS, ST_CNS2,
    ST_NSUM, ST_MULA, ST_SAT, ST_CHK, ST_EXP, ST_U0, ST_U1, ST_FIN
  } state_e;

  localparam logic signed [33:0] SAT_MAX = 34'sd8388607;
  localparam logic signed [33:0] SAT_MIN = -34'sd8388608;

  state_e state_q, state_d;
  logic [SIDX_W-1:0] clr_q, clr_d;
  req_t req_q, req_d;
  logic [3:0] cnt_q, cnt_d;
  coord_t slot_q [3];
  coord_t slot_d [3];
  coord_t new_q, new_d, old_q, old_d;
  logic [BIDX_W-1:0] bidx_q, bidx_d;
  logic signed [8:0] sum_q, sum_d;
  logic signed [33:0] prod_q, prod_d;
  logic signed [E_W-1:0] de_q, de_d;
  logic [24:0] acc_q, acc_d;
  logic [3:0] n_q, n_d;
  logic [3:0] k_q, k_d;
  logic ok_q, ok_d, bad_q, bad_d, upd_q, upd_d;
  logic valid_q, valid_d;
  res_t res_q, res_d;
  logic signed [E_W-1:0] attract_q, overlap_q;

  logic [CNT_W-1:0] cmem [NSITES];
  coord_t bmem [NBEADS];
  logic [SIDX_W-1:0] c_addr;
  logic c_we;
  logic [CNT_W-1:0] c_wd, c_rd_q;
  logic [BIDX_W-1:0] b_addr;
  logic b_we;
  coord_t b_wd, b_rd_q;

  function automatic logic [SIDX_W-1:0] site_of(coord_t c);
    return SIDX_W'(c.x) + SIDX_W'(BOX_X) * (SIDX_W'(c.y) + SIDX_W'(BOX_Y) * SIDX_W'(c.z));
  endfunction

  function automatic logic [SIDX_W-1:0] nbr_site(coord_t c, logic [2:0] j);
    coord_t n;
    n = c;
    case (j)
      3'd0: n.x = (int'(c.x) == BOX_X - 1) ? '0 : c.x + 1'b1;
      3'd1: n.x = (c.x == '0) ? X_W'(BOX_X - 1) : c.x - 1'b1;
      3'd2: n.y = (int'(c.y) == BOX_Y - 1) ? '0 : c.y + 1'b1;
      3'd3: n.y = (c.y == '0) ? Y_W'(BOX_Y - 1) : c.y - 1'b1;
      3'd4: n.z = (int'(c.z) == BOX_Z - 1) ? '0 : c.z + 1'b1;
      3'd5: n.z = (c.z == '0) ? Z_W'(BOX_Z - 1) : c.z - 1'b1;
      default: n = c;
    endcase
    return site_of(n);
  endfunction

  function automatic logic signed [8:0] sx(logic [Z_W-1:0] v);
    return $signed(9'(v));
  endfunction

  function automatic logic [Z_W-1:0] wrap1(logic signed [8:0] v, int box);
    logic [Z_W-1:0] r;
    if (v < 0) r = Z_W'(box - 1);
    else if (int'(v) > box - 1) r = '0;
    else r = v[Z_W-1:0];
    return r;
  endfunction

  // request decode
  logic [BIDX_W-1:0] base;
  logic [BIDX_W-1:0] req_bidx;
  logic req_bad;
  coord_t ld_c;
  always_comb begin
    base = BIDX_W'(req_q.chain_id) * BIDX_W'(BEADS_PER_CHAIN);
    req_bidx = BIDX_W'(req_i.chain_id) * BIDX_W'(BEADS_PER_CHAIN) + BIDX_W'(req_i.bead_id);
    if (int'(req_i.chain_id) >= NUM_CHAINS) req_bad = 1'b1;
    else if (req_i.cmd == CMD_LOAD) req_bad = int'(req_i.bead_id) >= BEADS_PER_CHAIN;
    else if (req_i.cmd == CMD_INNER)
      req_bad = (req_i.bead_id == '0) || (int'(req_i.bead_id) > BEADS_PER_CHAIN - 2);
    else req_bad = req_i.direction > DIR_LAST;
    ld_c.x = (int'(req_q.load_x) > BOX_X - 1) ? X_W'(BOX_X - 1) : req_q.load_x;
    ld_c.y = (int'(req_q.load_y) > BOX_Y - 1) ? Y_W'(BOX_Y - 1) : req_q.load_y;
    ld_c.z = (int'(req_q.load_z) > BOX_Z - 1) ? Z_W'(BOX_Z - 1) : req_q.load_z;
  end

  // proposal
  coord_t prop_c, prop_old;
  always_comb begin
    logic signed [8:0] dx, dy, dz, vx, vy, vz, ax, ay, az, cx, cy, cz, px, py, pz;
    logic signed [17:0] dot;
    dx = 9'(STEP_X[req_q.direction[2:0]]);
    dy = 9'(STEP_Y[req_q.direction[2:0]]);
    dz = 9'(STEP_Z[req_q.direction[2:0]]);
    ax = sx(Z_W'(slot_q[2].x)) - sx(Z_W'(slot_q[1].x));
    ay = sx(Z_W'(slot_q[2].y)) - sx(Z_W'(slot_q[1].y));
    az = sx(slot_q[2].z) - sx(slot_q[1].z);
    cx = sx(Z_W'(slot_q[1].x)) - sx(Z_W'(slot_q[0].x));
    cy = sx(Z_W'(slot_q[1].y)) - sx(Z_W'(slot_q[0].y));
    cz = sx(slot_q[1].z) - sx(slot_q[0].z);
    dot = 18'(ax) * 18'(cx) + 18'(ay) * 18'(cy) + 18'(az) * 18'(cz);
    if (req_q.cmd == CMD_FIRST) begin
      vx = cx; vy = cy; vz = cz;
    end else begin
      vx = -cx; vy = -cy; vz = -cz;
    end
    prop_old = slot_q[0];
    if (req_q.cmd == CMD_INNER) begin
      prop_old = slot_q[1];
      if (dot != 0) begin
        px = sx(Z_W'(slot_q[1].x)); py = sx(Z_W'(slot_q[1].y)); pz = sx(slot_q[1].z);
      end else begin
        px = sx(Z_W'(slot_q[0].x)) + ax;
        py = sx(Z_W'(slot_q[0].y)) + ay;
        pz = sx(slot_q[0].z) + az;
      end
    end else if (vx == dx && vy == dy && vz == dz) begin
      px = sx(Z_W'(slot_q[0].x)); py = sx(Z_W'(slot_q[0].y)); pz = sx(slot_q[0].z);
    end else if (req_q.cmd == CMD_FIRST) begin
      px = sx(Z_W'(slot_q[1].x)) - dx;
      py = sx(Z_W'(slot_q[1].y)) - dy;
      pz = sx(slot_q[1].z) - dz;
    end else begin
      px = sx(Z_W'(slot_q[1].x)) + dx;
      py = sx(Z_W'(slot_q[1].y)) + dy;
      pz = sx(slot_q[1].z) + dz;
    end
    prop_c.x = X_W'(wrap1(px, BOX_X));
    prop_c.y = Y_W'(wrap1(py, BOX_Y));
    prop_c.z = wrap1(pz, BOX_Z);
  end

  // shared exp multiplier
  logic [23:0] m_const;
  logic [48:0] m_prod;
  logic [25:0] p_round;
  always_comb begin
    m_const = (n_q != '0) ? EXP_ONE : EXP_FRAC[k_q[2:0]];
    m_prod  = 49'(acc_q) * 49'(m_const) + 49'(ONE_Q24 >> 1);
    p_round = 26'(acc_q) + 26'd128;
  end

  // store ports
  always_comb begin
    c_addr = site_of(new_q);
    c_we = 1'b0;
    c_wd = (c_rd_q == CNT_W'(CNT_MAX)) ? c_rd_q : c_rd_q + 1'b1;
    b_addr = bidx_q;
    b_we = 1'b0;
    b_wd = new_q;
    case (state_q)
      ST_CLR: begin
        c_addr = clr_q;
        c_we = 1'b1;
        c_wd = '0;
      end
      ST_LD0: begin
        b_addr = base + BIDX_W'(req_q.bead_id);
        b_we = 1'b1;
        b_wd = ld_c;
        c_addr = site_of(ld_c);
      end
      ST_LD1: begin
        c_addr = site_of(ld_c);
        c_we = 1'b1;
      end
      ST_RD: begin
        if (req_q.cmd == CMD_INNER) b_addr = base + BIDX_W'(req_q.bead_id) - 1'b1 + BIDX_W'(cnt_q);
        else if (req_q.cmd == CMD_FIRST) b_addr = (cnt_q == '0) ? base : base + 1'b1;
        else b_addr = (cnt_q == '0) ? base + BIDX_W'(BEADS_PER_CHAIN - 1)
                                    : base + BIDX_W'(BEADS_PER_CHAIN - 2);
      end
      ST_NSUM: begin
        if (cnt_q < 4'd6) c_addr = nbr_site(new_q, cnt_q[2:0]);
        else c_addr = nbr_site(old_q, 3'(cnt_q - 4'd6));
      end
      ST_U0: begin
        c_addr = site_of(old_q);
        b_we = 1'b1;
      end
      ST_U1: begin
        c_addr = site_of(old_q);
        c_we = 1'b1;
        c_wd = (c_rd_q == '0) ? '0 : c_rd_q - 1'b1;
      end
      ST_FIN: begin
        c_we = upd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (c_we) cmem[c_addr] <= c_wd;
    c_rd_q <= cmem[c_addr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) bmem[b_addr] <= b_wd;
    b_rd_q <= bmem[b_addr];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    req_d = req_q;
    cnt_d = cnt_q;
    slot_d = slot_q;
    new_d = new_q;
    old_d = old_q;
    bidx_d = bidx_q;
    sum_d = sum_q;
    prod_d = prod_q;
    de_d = de_q;
    acc_d = acc_q;
    n_d = n_q;
    k_d = k_q;
    ok_d = ok_q;
    bad_d = bad_q;
    upd_d = upd_q;
    valid_d = 1'b0;
    res_d = res_q;
    case (state_q)
      ST_CLR: begin
        clr_d = clr_q + 1'b1;
        if (int'(clr_q) == NSITES - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          bad_d = req_bad;
          ok_d = 1'b0;
          upd_d = 1'b0;
          de_d = '0;
          cnt_d = '0;
          bidx_d = req_bidx;
          if (req_bad) state_d = ST_FIN;
          else if (req_i.cmd == CMD_LOAD) state_d = ST_LD0;
          else state_d = ST_RD;
        end
      end
      ST_LD0: begin
        state_d = ST_LD1;
      end
      ST_LD1: begin
        new_d = ld_c;
        ok_d = 1'b1;
        state_d = ST_FIN;
      end
      ST_RD: begin
        if (cnt_q != '0) slot_d[cnt_q[1:0] - 2'd1] = b_rd_q;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd3) state_d = ST_PROP;
      end
      ST_PROP: begin
        new_d = prop_c;
        old_d = prop_old;
        if (req_q.cmd == CMD_FIRST) bidx_d = base;
        else if (req_q.cmd == CMD_LAST) bidx_d = base + BIDX_W'(BEADS_PER_CHAIN - 1);
        else bidx_d = base + BIDX_W'(req_q.bead_id);
        state_d = ST_CNS;
      end
      ST_CNS: begin
        state_d = ST_CNS2;
      end
      ST_CNS2: begin
        if (c_rd_q != '0) begin
          prod_d = 34'($signed({1'b0, c_rd_q})) * 34'(overlap_q);
          state_d = ST_SAT;
        end else begin
          cnt_d = '0;
          sum_d = '0;
          state_d = ST_NSUM;
        end
      end
      ST_NSUM: begin
        if (cnt_q != '0) begin
          if (cnt_q <= 4'd6) sum_d = sum_q + $signed(9'(c_rd_q));
          else sum_d = sum_q - $signed(9'(c_rd_q));
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd12) state_d = ST_MULA;
      end
      ST_MULA: begin
        prod_d = 34'(sum_q) * 34'(attract_q);
        state_d = ST_SAT;
      end
      ST_SAT: begin
        if (prod_q > SAT_MAX) de_d = SAT_MAX[E_W-1:0];
        else if (prod_q < SAT_MIN) de_d = SAT_MIN[E_W-1:0];
        else de_d = prod_q[E_W-1:0];
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (de_q <= 0) begin
          ok_d = 1'b1;
          state_d = ST_U0;
        end else if (de_q >= E_W'(EXP_N_MAX * 256)) begin
          ok_d = (req_q.rand_frac == '0);
          state_d = (req_q.rand_frac == '0) ? ST_U0 : ST_FIN;
        end else begin
          acc_d = ONE_Q24;
          n_d = de_q[11:8];
          k_d = '0;
          state_d = ST_EXP;
        end
      end
      ST_EXP: begin
        if (n_q != '0) begin
          acc_d = m_prod[48:24];
          n_d = n_q - 1'b1;
        end else if (k_q != 4'd8) begin
          if (de_q[3'd7 - k_q[2:0]]) acc_d = m_prod[48:24];
          k_d = k_q + 1'b1;
        end else begin
          ok_d = p_round[25:8] >= 18'(req_q.rand_frac);
          state_d = (p_round[25:8] >= 18'(req_q.rand_frac)) ? ST_U0 : ST_FIN;
        end
      end
      ST_U0: begin
        state_d = ST_U1;
      end
      ST_U1: begin
        upd_d = 1'b1;
        cnt_d = '0;
        state_d = ST_CNS;
      end
      ST_FIN: begin
        valid_d = 1'b1;
        res_d.accepted = ok_q && !bad_q;
        res_d.new_x = bad_q ? '0 : new_q.x;
        res_d.new_y = bad_q ? '0 : new_q.y;
        res_d.new_z = bad_q ? '0 : new_q.z;
        res_d.energy_change = bad_q ? '0 : de_q;
        res_d.bad_request = bad_q;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    // after the old-site write, revisit the target: its count read feeds the increment
    if (state_q == ST_CNS2 && upd_q) begin
      prod_d = prod_q;
      state_d = ST_FIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q <= '0;
      cnt_q <= '0;
      ok_q <= 1'b0;
      bad_q <= 1'b0;
      upd_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      cnt_q <= cnt_d;
      ok_q <= ok_d;
      bad_q <= bad_d;
      upd_q <= upd_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    slot_q <= slot_d;
    new_q <= new_d;
    old_q <= old_d;
    bidx_q <= bidx_d;
    sum_q <= sum_d;
    prod_q <= prod_d;
    de_q <= de_d;
    acc_q <= acc_d;
    n_q <= n_d;
    k_q <= k_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attract_q <= ATTRACT_RST;
      overlap_q <= OVERLAP_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ATTRACT) attract_q <= cfg_data_i;
      if (cfg_index_i == CFG_OVERLAP) overlap_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign res_o = res_q;

`ifndef ASSERT_OFF
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy) else $error("result strobe while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request taken but not busy");
  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than one cycle");
  a_bad_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && res_o.bad_request) |-> !res_o.accepted)
    else $error("refused request reported accepted");
`endif

endmodule
